// File: src/video_header_start_code_scan_unit_assert.svh
// Assertion macros shared by the header start-code scan RTL.
// Include after the module ports; no other dependencies.
`ifndef VIDEO_HEADER_START_CODE_SCAN_UNIT_ASSERT_SVH
`define VIDEO_HEADER_START_CODE_SCAN_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VHSCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("start-code scan: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define VHSCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("start-code scan: next-cycle check failed");

`endif

// File: src/vhscs_pkg.sv
// Package for the video header start-code scan unit.
// Holds widths, start-code byte constants and the result record type.
`timescale 1ns / 1ps

package vhscs_pkg;

    localparam int unsigned OffW         = 12;
    localparam int unsigned PosW         = 13;
    localparam int unsigned BUFFER_BYTES = 4096;

    localparam logic [OffW-1:0] LimitReset = 12'd1000;
    localparam logic [PosW-1:0] PosMax     = 13'd8191;

    localparam logic [7:0] CodeVosNib  = 8'hB0;
    localparam logic [7:0] CodeVolNib  = 8'h00;
    localparam logic [7:0] CodeVop     = 8'hB6;
    localparam logic [7:0] CodeH263    = 8'h80;
    localparam logic [7:0] NibMask     = 8'hF0;
    localparam logic [23:0] Prefix3    = 24'h000001;

    typedef struct packed {
        logic [OffW-1:0] header_offset;
        logic            short_header;
        logic            code_found;
    } t_result;

endpackage

// File: src/vhscs_scan.sv
// Per-byte start-code matcher and scan state for the header scan unit.
// Depends on vhscs_pkg; produces one result record on the final byte.
`timescale 1ns / 1ps

module vhscs_scan
    import vhscs_pkg::*;
#(
    parameter int unsigned BUF_BYTES = BUFFER_BYTES
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_data_byte,
    input  logic            i_last_byte,
    input  logic [OffW-1:0] i_limit,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [16:0] BufLimit = 17'(BUF_BYTES);

    logic [23:0]     r_recent, n_recent;
    logic [PosW-1:0] r_pos, n_pos;
    logic            r_opens, n_opens;
    logic            r_pic_seen, n_pic_seen;
    logic [OffW-1:0] r_pic_off, n_pic_off;
    logic            r_h263_seen, n_h263_seen;
    logic [OffW-1:0] r_h263_off, n_h263_off;
    logic            r_flag, n_flag;

    logic            in_buf;
    logic            pref3;
    logic [PosW-1:0] start3;
    logic [PosW-1:0] start2;
    logic            pic_hit;
    logic            h263_hit;
    t_result         res;

    always_comb begin
        in_buf   = ({4'b0, r_pos} < BufLimit);
        pref3    = (r_recent == Prefix3);
        start3   = r_pos - PosW'(3);
        start2   = r_pos - PosW'(2);
        pic_hit  = in_buf && (r_pos >= PosW'(3)) && !r_pic_seen && pref3
                   && (i_data_byte == CodeVop) && (start3 <= {1'b0, i_limit});
        h263_hit = in_buf && (r_pos >= PosW'(2)) && !r_h263_seen
                   && (r_recent[15:0] == 16'h0000) && (i_data_byte == CodeH263)
                   && !start2[PosW-1];

        n_opens = r_opens;
        if (in_buf && (r_pos == PosW'(3))) begin
            n_opens = pref3 && (((i_data_byte & NibMask) == CodeVosNib)
                               || ((i_data_byte & NibMask) == CodeVolNib));
        end
        n_pic_seen  = r_pic_seen  || pic_hit;
        n_pic_off   = pic_hit  ? start3[OffW-1:0] : r_pic_off;
        n_h263_seen = r_h263_seen || h263_hit;
        n_h263_off  = h263_hit ? start2[OffW-1:0] : r_h263_off;
        n_recent    = {r_recent[15:0], i_data_byte};
        n_pos       = (r_pos < PosMax) ? r_pos + PosW'(1) : r_pos;

        res.header_offset = '0;
        res.short_header  = r_flag;
        res.code_found    = 1'b1;
        if (r_pos < PosW'(3)) begin
            res.short_header = r_flag;
        end else if (!n_opens) begin
            res.short_header = 1'b1;
        end else if (n_pic_seen) begin
            res.short_header  = 1'b0;
            res.header_offset = n_pic_off;
        end else begin
            res.short_header = 1'b1;
            if (n_h263_seen) begin
                res.header_offset = n_h263_off;
            end else begin
                res.code_found = 1'b0;
            end
        end
        n_flag = i_last_byte ? res.short_header : r_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recent    <= '0;
            r_pos       <= '0;
            r_opens     <= 1'b0;
            r_pic_seen  <= 1'b0;
            r_pic_off   <= '0;
            r_h263_seen <= 1'b0;
            r_h263_off  <= '0;
            r_flag      <= 1'b0;
        end else if (i_accept) begin
            r_flag <= n_flag;
            if (i_last_byte) begin
                r_recent    <= '0;
                r_pos       <= '0;
                r_opens     <= 1'b0;
                r_pic_seen  <= 1'b0;
                r_pic_off   <= '0;
                r_h263_seen <= 1'b0;
                r_h263_off  <= '0;
            end else begin
                r_recent    <= n_recent;
                r_pos       <= n_pos;
                r_opens     <= n_opens;
                r_pic_seen  <= n_pic_seen;
                r_pic_off   <= n_pic_off;
                r_h263_seen <= n_h263_seen;
                r_h263_off  <= n_h263_off;
            end
        end
    end

    assign o_res_valid = i_accept && i_last_byte;
    assign o_res       = res;

endmodule

// File: src/vhscs_out_reg.sv
// Output result register for the header scan unit.
// Depends on vhscs_pkg for the result record.
`timescale 1ns / 1ps

module vhscs_out_reg
    import vhscs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    output logic    o_can_load,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// File: src/video_header_start_code_scan_unit.sv
// Video header start-code scan unit: top level.
// Bytes of a bitstream buffer enter on the slave stream, one per transaction,
// with tlast on the final byte. The first four bytes decide whether the
// stream opens with a header code; the unit then tracks the first picture
// start code within the configured limit and the first short-header code.
// A single result transaction leaves on the master stream in the cycle after
// the final byte is taken: header offset in tdata, flags in tuser. One byte
// is taken every cycle; the result register decides tready, so a byte is
// refused only while an unaccepted result sits in the register. The user must
// write the search limit on the cfg channel, always ready, only while idle;
// the block does not check it. Reset clears the scan state, the short-header
// flag and the output register and loads the limit with 1000. There is no
// clearing pass after reset. When the receiver stalls, the result is held and
// tready stays low until it is taken, so no byte is accepted during the stall.
`timescale 1ns / 1ps

module video_header_start_code_scan_unit
    import vhscs_pkg::*;
#(
    parameter int unsigned BUF_BYTES = BUFFER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] header_offset, [15:12] zero
    output logic [1:0]  m_axis_tuser,   // [0] short_header, [1] code_found
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [11:0] i_cfg_data      // [11:0] vop_search_limit
);

    logic [OffW-1:0] r_limit;
    logic            accept;
    logic            res_valid;
    t_result         res;
    t_result         out_res;
    logic            can_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LimitReset;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    vhscs_scan #(
        .BUF_BYTES (BUF_BYTES)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (s_axis_tdata),
        .i_last_byte (s_axis_tlast),
        .i_limit     (r_limit),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    vhscs_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_load  (can_load),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {4'b0, out_res.header_offset};
    assign m_axis_tuser = {out_res.code_found, out_res.short_header};

`include "video_header_start_code_scan_unit_assert.svh"

    `VHSCS_ASSERT_NOW(a_missing_code_is_short, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[1], m_axis_tuser[0])
    `VHSCS_ASSERT_NOW(a_missing_code_zero_offset, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == 16'h0000)
    `VHSCS_ASSERT_NOW(a_picture_within_limit, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[11:0] <= r_limit)
    `VHSCS_ASSERT_NEXT(a_last_byte_gives_result, i_clk, i_rst_n,
        accept && s_axis_tlast, m_axis_tvalid)

endmodule
